// ===== src/lcmw_pkg.sv =====
// lcmw_pkg: shared constants and types for the load-cell median weigher.
// No dependencies; the RTL files refer to it by scoped names and the bench imports it.
package lcmw_pkg;

  localparam int OFFSET_W   = 24;
  localparam int DIVISOR_W  = 16;
  localparam int WEIGHT_W   = 33;
  localparam int MEDIAN_W   = 24;
  localparam int FRAC_BITS  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_GRAM = 2'd1;

  localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 24'd125000;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd1000;

  // positive limit and magnitude of the negative limit of the weight
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 33'h0_FFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN_MAG = 33'h1_0000_0000;

  typedef struct packed {
    logic wr;
    logic start;
  } sel_ctl_t;

endpackage

// ===== src/lcmw_intf.sv =====
// Handshake interfaces for the sample and result channels.
// Depends on lcmw_pkg for the result field widths.
interface lcmw_sample_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface lcmw_result_if ();
  logic                                   valid;
  logic                                   ready;
  logic signed [lcmw_pkg::WEIGHT_W-1:0]   weight_q8;
  logic signed [lcmw_pkg::MEDIAN_W-1:0]   median_raw;

  modport source (output valid, output weight_q8, output median_raw, input ready);
  modport sink   (input valid, input weight_q8, input median_raw, output ready);
endinterface

// ===== src/load_cell_median_weigher_top.sv =====
// Load-cell median weigher top: sample window control, configuration
// registers and result register. Depends on lcmw_pkg, lcmw_intf,
// lcmw_select and lcmw_divider.
//
//   channel   dir  handshake      payload
//   sample_i  in   valid/ready    raw_sample
//   result_o  out  valid/ready    weight_q8, median_raw
//   cfg       in   cfg_we_i       cfg_index_i, cfg_wdata_i
//
// Samples are taken one per cycle until the window is full. The sample that
// completes the window is followed by a bit-serial median search and
// max(SAMPLE_BITS,24)+8 divide steps before sample_i opens again. Reset
// clears the window count, the control state and loads the register defaults.
// A stalled result holds in the output register; sampling resumes once it is
// moved.
module load_cell_median_weigher_top #(
  parameter int WINDOW      = 7,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lcmw_sample_if.sink                         sample_i,
  lcmw_result_if.source                       result_o,
  input  logic                                cfg_we_i,
  input  logic [lcmw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lcmw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int IW = $clog2(WINDOW);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_MEDIAN  = 2'd1;
  localparam logic [1:0] ST_DIVIDE  = 2'd2;
  localparam logic [1:0] ST_HOLD    = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] fill_q, fill_d;
  logic          accept, last, load;

  logic signed [lcmw_pkg::OFFSET_W-1:0] offset_q;
  logic [lcmw_pkg::DIVISOR_W-1:0]       cpg_q;

  lcmw_pkg::sel_ctl_t            sel_ctl;
  logic                          sel_done, div_done;
  logic signed [SAMPLE_BITS-1:0] sel_median;
  logic [lcmw_pkg::WEIGHT_W-1:0] div_weight;

  logic                                 out_valid_q;
  logic signed [lcmw_pkg::WEIGHT_W-1:0] out_weight_q;
  logic signed [lcmw_pkg::MEDIAN_W-1:0] out_median_q;

  assign sample_i.ready = (state_q == ST_COLLECT);
  assign accept         = sample_i.valid && sample_i.ready;
  assign last           = (fill_q == IW'(WINDOW - 1));
  assign load           = (state_q == ST_HOLD) && (!out_valid_q || result_o.ready);
  assign sel_ctl.wr     = accept;
  assign sel_ctl.start  = accept && last;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (accept) begin
          if (last) begin
            fill_d  = '0;
            state_d = ST_MEDIAN;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_MEDIAN: begin
        if (sel_done) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (load) state_d = ST_COLLECT;
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= lcmw_pkg::OFFSET_RESET;
      cpg_q    <= lcmw_pkg::DIVISOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lcmw_pkg::REG_ZERO_OFFSET:     offset_q <= lcmw_pkg::OFFSET_W'(cfg_wdata_i);
        lcmw_pkg::REG_COUNTS_PER_GRAM: cpg_q    <= cfg_wdata_i[lcmw_pkg::DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  lcmw_select #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (sel_ctl),
    .wr_idx_i  (fill_q),
    .wr_data_i (sample_i.raw_sample),
    .done_o    (sel_done),
    .median_o  (sel_median)
  );

  lcmw_divider #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sel_done),
    .median_i  (sel_median),
    .offset_i  (offset_q),
    .divisor_i (cpg_q),
    .done_o    (div_done),
    .weight_o  (div_weight)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_weight_q <= div_weight;
      out_median_q <= lcmw_pkg::MEDIAN_W'(sel_median);
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.weight_q8  = out_weight_q;
  assign result_o.median_raw = out_median_q;

  a_done_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sel_done && div_done))
    else $error("median and divide completions overlap");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= IW'(WINDOW - 1))
    else $error("window count out of range");

  a_median_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_done |=> (state_q == ST_DIVIDE))
    else $error("median done without divide start");

endmodule

// ===== src/lcmw_select.sv =====
// lcmw_select: window store as shift registers and bit-serial median search,
// one result bit per cycle, MSB first. Depends on lcmw_pkg.
module lcmw_select #(
  parameter int WINDOW      = 7,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcmw_pkg::sel_ctl_t            ctl_i,
  input  logic [$clog2(WINDOW)-1:0]     wr_idx_i,
  input  logic [SAMPLE_BITS-1:0]        wr_data_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] median_o
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int BW = $clog2(SAMPLE_BITS);

  logic [SAMPLE_BITS-1:0] win_q [WINDOW];
  logic [WINDOW-1:0]      cand_q, cand_d, key;
  logic [CW-1:0]          rank_q, rank_d, zeros;
  logic [BW-1:0]          cnt_q;
  logic                   busy_q, done_q;
  logic                   first, bit_ord;
  logic signed [SAMPLE_BITS-1:0] med_q;

  assign first = (cnt_q == '0);

  // sign bit is inverted on the first step so that ordering is signed
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      key[i] = win_q[i][SAMPLE_BITS-1] ^ first;
    end
    zeros = CW'($countones(cand_q & ~key));
    if (rank_q < zeros) begin
      cand_d  = cand_q & ~key;
      rank_d  = rank_q;
      bit_ord = 1'b0;
    end else begin
      cand_d  = cand_q & key;
      rank_d  = rank_q - zeros;
      bit_ord = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      win_q[wr_idx_i] <= wr_data_i;
    end else if (busy_q) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= win_q[i] << 1;
      end
    end
    if (ctl_i.start) begin
      cand_q <= '1;
      rank_q <= CW'(WINDOW / 2);
    end else if (busy_q) begin
      cand_q <= cand_d;
      rank_q <= rank_d;
      med_q  <= {med_q[SAMPLE_BITS-2:0], bit_ord ^ first};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == BW'(SAMPLE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign median_o = med_q;

endmodule

// ===== src/lcmw_divider.sv =====
// lcmw_divider: offset correction, radix-2 restoring divide one quotient bit
// per cycle, sign restore and saturation. Depends on lcmw_pkg.
module lcmw_divider #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [SAMPLE_BITS-1:0]         median_i,
  input  logic signed [lcmw_pkg::OFFSET_W-1:0]  offset_i,
  input  logic [lcmw_pkg::DIVISOR_W-1:0]        divisor_i,
  output logic                                  done_o,
  output logic [lcmw_pkg::WEIGHT_W-1:0]         weight_o
);

  localparam int AW = (SAMPLE_BITS > lcmw_pkg::OFFSET_W) ? SAMPLE_BITS : lcmw_pkg::OFFSET_W;
  localparam int QW = AW + lcmw_pkg::FRAC_BITS;
  localparam int DW = lcmw_pkg::DIVISOR_W;
  localparam int KW = $clog2(QW);
  localparam int WW = lcmw_pkg::WEIGHT_W;
  localparam logic [QW:0] POS_LIM = (QW + 1)'(lcmw_pkg::WEIGHT_MAX);
  localparam logic [QW:0] NEG_LIM = (QW + 1)'(lcmw_pkg::WEIGHT_MIN_MAG);

  logic signed [AW:0] med_x, off_x, diff_a, diff_b;
  logic [AW-1:0]      mag;
  logic               neg;
  logic [QW-1:0]      dvd_q;
  logic [DW-1:0]      rem_q, div_q, rem_d;
  logic [DW:0]        sh, sub;
  logic               ge, neg_q;
  logic [KW-1:0]      cnt_q;
  logic               busy_q, fin_q, done_q;
  logic [WW-1:0]      mag_w, weight_d, weight_q;

  // magnitude of median - offset, two subtractors side by side
  always_comb begin
    med_x  = (AW + 1)'(median_i);
    off_x  = (AW + 1)'(offset_i);
    diff_a = med_x - off_x;
    diff_b = off_x - med_x;
    neg    = diff_a[AW];
    mag    = neg ? diff_b[AW-1:0] : diff_a[AW-1:0];
  end

  always_comb begin
    sh    = {rem_q, dvd_q[QW-1]};
    sub   = sh - {1'b0, div_q};
    ge    = (sh >= {1'b0, div_q});
    rem_d = ge ? sub[DW-1:0] : sh[DW-1:0];
  end

  always_comb begin
    mag_w = WW'(dvd_q);
    if (!neg_q && ({1'b0, dvd_q} > POS_LIM)) begin
      weight_d = lcmw_pkg::WEIGHT_MAX;
    end else if (neg_q && ({1'b0, dvd_q} > NEG_LIM)) begin
      weight_d = lcmw_pkg::WEIGHT_MIN_MAG;
    end else begin
      weight_d = neg_q ? (WW'(0) - mag_w) : mag_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, {lcmw_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
      div_q <= (divisor_i == '0) ? DW'(1) : divisor_i;
      neg_q <= neg;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[QW-2:0], ge};
      rem_q <= rem_d;
    end
    if (fin_q) begin
      weight_q <= weight_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == KW'(QW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign weight_o = weight_q;

endmodule

// ===== tb/load_cell_median_weigher_top_test.sv =====
// Self-checking bench for load_cell_median_weigher_top: random-gap sample driver, stalling
// result sink, and a window/median/divide predictor checked field by field in order.
// Depends on lcmw_pkg, lcmw_intf and the RTL under src/.
module load_cell_median_weigher_top_test;
  import lcmw_pkg::*;

  localparam int WIN = 7;
  localparam int SBITS = 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;
  localparam longint SMP_MAX = 64'sd8388607;
  localparam longint SMP_MIN = -64'sd8388608;
  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT = 25;
  localparam int RAND_PHASES = 6;
  localparam int WINDOWS_PER_PHASE = 15;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_q8;
    logic signed [MEDIAN_W-1:0] median_raw;
  } weighing_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_e;
  typedef enum int {WK_UNIFORM, WK_CLUSTER, WK_DUPES, WK_SPIKES} win_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic smp_valid = 1'b0;
  logic signed [SBITS-1:0] smp_data = '0;
  logic res_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lcmw_sample_if #(.SAMPLE_BITS(SBITS)) smp_if ();
  lcmw_result_if res_if ();

  assign smp_if.valid = smp_valid;
  assign smp_if.raw_sample = smp_data;
  assign res_if.ready = res_ready;

  load_cell_median_weigher_top #(.WINDOW(WIN), .SAMPLE_BITS(SBITS)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_i   (smp_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state and expected weighings
  logic signed [SBITS-1:0] win_buf [WIN];
  int unsigned win_fill = 0;
  logic signed [OFFSET_W-1:0] zero_offset_m = OFFSET_RESET;
  logic [DIVISOR_W-1:0] cpg_m = DIVISOR_RESET;
  weighing_t weighings_q [$];
  logic signed [SBITS-1:0] sample_q [$];

  int err_cnt = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int reg_writes = 0;

  function automatic logic signed [SBITS-1:0] clamp24(longint v);
    if (v > SMP_MAX) v = SMP_MAX;
    if (v < SMP_MIN) v = SMP_MIN;
    return v[SBITS-1:0];
  endfunction

  function automatic weighing_t weigh_window();
    logic signed [SBITS-1:0] srt [WIN];
    logic signed [SBITS-1:0] key;
    longint diff, q, div, lim;
    int j;
    weighing_t w;
    srt = win_buf;
    for (int i = 1; i < WIN; i++) begin
      key = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > key) begin
        srt[j + 1] = srt[j];
        j--;
      end
      srt[j + 1] = key;
    end
    // zero divisor acts as one
    div = (cpg_m == '0) ? 64'sd1 : longint'({48'd0, cpg_m});
    diff = longint'(srt[WIN / 2]) - longint'(zero_offset_m);
    q = (diff * 256) / div;
    lim = (64'sd1 <<< (WEIGHT_W - 1)) - 64'sd1;
    if (q > lim) q = lim;
    if (q < -lim - 1) q = -lim - 1;
    w.weight_q8 = q[WEIGHT_W-1:0];
    w.median_raw = srt[WIN / 2];
    return w;
  endfunction

  // sample driver: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      smp_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (smp_valid && smp_if.ready) begin
        win_buf[win_fill] = smp_data;
        win_fill++;
        if (win_fill == WIN) begin
          win_fill = 0;
          weighings_q.push_back(weigh_window());
        end
        samples_sent++;
      end
      if (!smp_valid || smp_if.ready) begin
        if (gap_left > 0) begin
          smp_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (sample_q.size() > 0) begin
          smp_valid <= 1'b1;
          smp_data <= sample_q.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left <= $urandom_range(30, 80);
            gap_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
          end
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // result sink: stall pattern plus one long hold
  rx_mode_e rx_mode = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      mode_left <= 0;
    end else if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      res_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN: res_ready <= 1'b1;
        RX_COIN: res_ready <= $urandom_range(0, 1);
        RX_SPARSE: res_ready <= ($urandom_range(0, 4) == 0);
        default: res_ready <= (mode_left[3:0] < 4'd6);
      endcase
    end
  end

  // result checker
  weighing_t exp_w;

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (weighings_q.size() == 0) begin
        $display("%0t: unexpected result: weight_q8 %0d median_raw %0d",
                 $time, res_if.weight_q8, res_if.median_raw);
        err_cnt++;
      end else begin
        exp_w = weighings_q.pop_front();
        if (res_if.weight_q8 !== exp_w.weight_q8) begin
          $display("%0t: weight_q8 mismatch: expected %0d, actual %0d",
                   $time, exp_w.weight_q8, res_if.weight_q8);
          err_cnt++;
        end
        if (res_if.median_raw !== exp_w.median_raw) begin
          $display("%0t: median_raw mismatch: expected %0d, actual %0d",
                   $time, exp_w.median_raw, res_if.median_raw);
          err_cnt++;
        end
      end
      results_seen++;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ZERO_OFFSET) zero_offset_m = data;
    else if (idx == REG_COUNTS_PER_GRAM) cpg_m = data[DIVISOR_W-1:0];
    reg_writes++;
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while ((sample_q.size() != 0 || smp_valid || weighings_q.size() != 0 || win_fill != 0)
           && n < IDLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_window(win_kind_e kind);
    logic signed [SBITS-1:0] r;
    longint base;
    r = SBITS'($urandom);
    base = ($urandom_range(0, 1) == 0) ? longint'(r)
         : longint'(zero_offset_m) + longint'($urandom_range(0, 400000)) - 200000;
    for (int i = 0; i < WIN; i++) begin
      case (kind)
        WK_UNIFORM: sample_q.push_back(SBITS'($urandom));
        WK_CLUSTER: sample_q.push_back(clamp24(base + longint'($urandom_range(0, 4000)) - 2000));
        WK_DUPES: sample_q.push_back(clamp24(base + longint'($urandom_range(0, 2)) - 1));
        default: begin
          if ($urandom_range(0, 2) == 0)
            sample_q.push_back(clamp24(($urandom_range(0, 1) == 0) ? SMP_MAX : SMP_MIN));
          else
            sample_q.push_back(clamp24(base + longint'($urandom_range(0, 600)) - 300));
        end
      endcase
    end
  endtask

  function automatic win_kind_e pick_kind();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p < 4) return WK_UNIFORM;
    if (p < 11) return WK_CLUSTER;
    if (p < 15) return WK_DUPES;
    return WK_SPIKES;
  endfunction

  logic [CFG_DATA_W-1:0] rnd_off;
  logic [DIVISOR_W-1:0] rnd_div;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, unsorted window with duplicates
    sample_q.push_back(24'sd125000);
    sample_q.push_back(-24'sd3);
    sample_q.push_back(clamp24(SMP_MAX));
    sample_q.push_back(24'sd125000);
    sample_q.push_back(clamp24(SMP_MIN));
    sample_q.push_back(24'sd0);
    sample_q.push_back(24'sd124999);
    wait_idle();

    // largest positive weight
    write_reg(REG_ZERO_OFFSET, 24'h800000);
    write_reg(REG_COUNTS_PER_GRAM, 24'h000001);
    repeat (WIN) sample_q.push_back(clamp24(SMP_MAX));
    wait_idle();

    // largest negative weight, zero divisor
    write_reg(REG_ZERO_OFFSET, 24'h7FFFFF);
    write_reg(REG_COUNTS_PER_GRAM, 24'hFF0000);
    repeat (WIN) sample_q.push_back(clamp24(SMP_MIN));
    wait_idle();

    // unmapped indexes ignored, largest divisor, truncation toward zero
    write_reg(REG_UNMAPPED_LO, 24'hFFFFFF);
    write_reg(REG_ZERO_OFFSET, 24'h000000);
    write_reg(REG_COUNTS_PER_GRAM, 24'h00FFFF);
    write_reg(REG_UNMAPPED_HI, 24'h000001);
    sample_q.push_back(-24'sd100000);
    sample_q.push_back(clamp24(SMP_MAX));
    sample_q.push_back(clamp24(SMP_MIN));
    sample_q.push_back(-24'sd100000);
    sample_q.push_back(24'sd7);
    sample_q.push_back(-24'sd7);
    sample_q.push_back(-24'sd100001);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: rnd_off = CFG_DATA_W'($urandom);
        1: rnd_off = CFG_DATA_W'(125000 + $urandom_range(0, 20000) - 10000);
        2: rnd_off = ($urandom_range(0, 1) == 0) ? 24'h7FFFFF : 24'h800000;
        default: rnd_off = CFG_DATA_W'($urandom_range(0, 64) - 32);
      endcase
      case ($urandom_range(0, 3))
        0: rnd_div = DIVISOR_W'($urandom_range(1, 16));
        1: rnd_div = DIVISOR_W'($urandom);
        2: rnd_div = DIVISOR_W'($urandom_range(900, 1100));
        default: rnd_div = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
      endcase
      write_reg(REG_ZERO_OFFSET, rnd_off);
      if ($urandom_range(0, 2) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  CFG_DATA_W'($urandom));
      write_reg(REG_COUNTS_PER_GRAM, {8'($urandom), rnd_div});
      for (int w = 0; w < WINDOWS_PER_PHASE; w++) queue_window(pick_kind());
    end

    wait_idle();
    if (weighings_q.size() != 0)
      $display("%0t: %0d expected weighings never arrived", $time, weighings_q.size());
    $display("Sent %0d samples, checked %0d weighings across %0d register writes,",
             samples_sent, results_seen, reg_writes);
    $display("with bursty input, stalling output and one %0d-cycle output hold.", HOLD_CYCLES);
    if (err_cnt == 0 && weighings_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: run timed out", $time);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/lcmw_pkg.sv
src/lcmw_intf.sv
src/lcmw_select.sv
src/lcmw_divider.sv
src/load_cell_median_weigher_top.sv
tb/load_cell_median_weigher_top_test.sv
